// ===== hdl/cct_pkg.sv =====
// Shared definitions for the style-sheet character tokenizer.
// Character codes, token kinds and the result record; no dependencies.
package cct_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int LINE_WIDTH_DEF  = 16;
  localparam int CHAR_W = 8;
  localparam int LINE_W = 16;

  localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    KIND_COMMENT  = 3'd0,
    KIND_AT_RULE  = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_PROPERTY = 3'd3,
    KIND_SELECTOR = 3'd4,
    KIND_CLOSE    = 3'd5,
    KIND_NONE     = 3'd7
  } kind_t;

  typedef struct packed {
    logic              append_valid;
    logic [CHAR_W-1:0] append_char;
    logic              token_valid;
    kind_t             token_kind;
    logic [LINE_W-1:0] token_line;
    logic              comment_underflow;
  } res_t;

endpackage

// ===== hdl/css_char_tokenizer_top.sv =====
// Top level of the style-sheet character tokenizer.
// Depends on cct_pkg, cct_core and cct_skid.
//
// Usage:
//   Input channel: ch, chunk_start, line_no with in_valid / in_stall. A
//   transfer happens at a rising edge with in_valid high and in_stall low.
//   Output channel: one result per input character (append_valid,
//   append_char, token_valid, token_kind, token_line, comment_underflow)
//   with out_valid / out_stall, same transfer rule.
//   A character's result is registered in the result register (first in the
//   skid register while the receiver stalls). Throughput is one character per
//   cycle while in_stall is low; the decision logic is a handful of compares
//   and counter steps between the state registers and the result register.
//   When the receiver stalls, one more character is still taken into a
//   skid register; in_stall then rises until the held result is taken.
//   Reset (rst, synchronous) clears the quote, comment, parenthesis and
//   at-rule state, sets the last token kind to none and empties both
//   output registers.
module css_char_tokenizer_top #(
  parameter int COUNT_WIDTH = cct_pkg::COUNT_WIDTH_DEF,
  parameter int LINE_WIDTH  = cct_pkg::LINE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cct_pkg::CHAR_W-1:0] ch,
  input  logic                       chunk_start,
  input  logic [cct_pkg::LINE_W-1:0] line_no,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       append_valid,
  output logic [cct_pkg::CHAR_W-1:0] append_char,
  output logic                       token_valid,
  output logic [2:0]                 token_kind,
  output logic [cct_pkg::LINE_W-1:0] token_line,
  output logic                       comment_underflow
);
  import cct_pkg::*;

  logic accept;
  res_t step_res;
  res_t out_res;

  assign accept = in_valid && !in_stall;

  cct_core #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .ch         (ch),
    .chunk_start(chunk_start),
    .line_no    (line_no),
    .res        (step_res)
  );

  cct_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(step_res),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign append_valid      = out_res.append_valid;
  assign append_char       = out_res.append_char;
  assign token_valid       = out_res.token_valid;
  assign token_kind        = out_res.token_kind;
  assign token_line        = out_res.token_line;
  assign comment_underflow = out_res.comment_underflow;

endmodule

// ===== hdl/cct_core.sv =====
// Tokenizer state and the per-character decision logic.
// Depends on cct_pkg. The result is combinational; state moves on each transfer.
module cct_core #(
  parameter int COUNT_WIDTH = cct_pkg::COUNT_WIDTH_DEF,
  parameter int LINE_WIDTH  = cct_pkg::LINE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [cct_pkg::CHAR_W-1:0] ch,
  input  logic                      chunk_start,
  input  logic [cct_pkg::LINE_W-1:0] line_no,
  output cct_pkg::res_t             res
);
  import cct_pkg::*;

  localparam int LW = (LINE_WIDTH < LINE_W) ? LINE_WIDTH : LINE_W;
  localparam logic [LINE_W-1:0] LINE_MASK = LINE_W'((64'd1 << LW) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic                   quote_odd, quote_odd_next;
  logic [COUNT_WIDTH-1:0] comment_depth, comment_depth_next;
  logic [COUNT_WIDTH-1:0] paren_depth, paren_depth_next;
  logic                   at_rule_wait, at_rule_wait_next;
  kind_t                  last_kind, last_kind_next;
  logic [CHAR_W-1:0]      prev_char;

  logic  app, tok, under, has_prev, free_text;
  kind_t kind;

  always_comb begin
    quote_odd_next     = quote_odd;
    comment_depth_next = comment_depth;
    paren_depth_next   = paren_depth;
    at_rule_wait_next  = at_rule_wait;
    last_kind_next     = last_kind;
    app   = 1'b1;
    tok   = 1'b0;
    under = 1'b0;
    kind  = KIND_COMMENT;
    has_prev  = !chunk_start;
    free_text = !quote_odd && (comment_depth == '0);

    case (ch) inside
      CH_AT: begin
        if (!quote_odd) begin
          at_rule_wait_next = 1'b1;
          app = 1'b0;
        end
      end
      CH_STAR: begin
        if (!at_rule_wait && !quote_odd && has_prev && prev_char == CH_SLASH &&
            comment_depth != CNT_MAX) begin
          comment_depth_next = comment_depth + CNT_ONE;
        end
      end
      CH_SLASH: begin
        if (!quote_odd && paren_depth == '0 && has_prev && prev_char == CH_STAR) begin
          tok = 1'b1;
          kind = KIND_COMMENT;
          last_kind_next = KIND_COMMENT;
          if (comment_depth == '0) under = 1'b1;
          else comment_depth_next = comment_depth - CNT_ONE;
        end
      end
      CH_LPAREN: begin
        if (!quote_odd && !at_rule_wait && paren_depth != CNT_MAX)
          paren_depth_next = paren_depth + CNT_ONE;
      end
      CH_RPAREN: begin
        if (!quote_odd && !at_rule_wait && paren_depth != '0)
          paren_depth_next = paren_depth - CNT_ONE;
      end
      CH_DQUOTE, CH_SQUOTE: begin
        if (comment_depth == '0) quote_odd_next = !quote_odd;
      end
      CH_SEMI, CH_LBRACE: begin
        if (free_text) begin
          if (at_rule_wait) begin
            kind = KIND_AT_RULE;
            at_rule_wait_next = 1'b0;
          end else begin
            kind = (ch == CH_SEMI) ? KIND_VALUE : KIND_SELECTOR;
          end
          last_kind_next = kind;
          tok = 1'b1;
          app = 1'b0;
        end
      end
      CH_COLON: begin
        // A colon whose last token was a brace close or a comment stays plain text.
        if (!at_rule_wait && last_kind != KIND_CLOSE && last_kind != KIND_COMMENT &&
            free_text) begin
          kind = KIND_PROPERTY;
          last_kind_next = KIND_PROPERTY;
          tok = 1'b1;
          app = 1'b0;
        end
      end
      CH_RBRACE: begin
        if (free_text) begin
          kind = KIND_CLOSE;
          last_kind_next = KIND_CLOSE;
          tok = 1'b1;
          app = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res.append_valid      = app;
    res.append_char       = app ? ch : '0;
    res.token_valid       = tok;
    res.token_kind        = tok ? kind : KIND_COMMENT;
    res.token_line        = tok ? (line_no & LINE_MASK) : '0;
    res.comment_underflow = under;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_odd     <= 1'b0;
      comment_depth <= '0;
      paren_depth   <= '0;
      at_rule_wait  <= 1'b0;
      last_kind     <= KIND_NONE;
      prev_char     <= '0;
    end else if (accept) begin
      quote_odd     <= quote_odd_next;
      comment_depth <= comment_depth_next;
      paren_depth   <= paren_depth_next;
      at_rule_wait  <= at_rule_wait_next;
      last_kind     <= last_kind_next;
      prev_char     <= ch;
    end
  end

endmodule

// ===== hdl/cct_skid.sv =====
// Two-entry output buffer: a result register backed by a skid register.
// Depends on cct_pkg. The upstream stall is registered and never combinational.
module cct_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cct_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output cct_pkg::res_t out_data
);
  import cct_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic out_free;

  assign full     = skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // The skid register only fills while the result register is held.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== hdl/cct_checker.sv =====
// Port-level checks for the tokenizer top level, attached by bind.
// Depends on cct_pkg and css_char_tokenizer_top.
module cct_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       append_valid,
  input logic [cct_pkg::CHAR_W-1:0] append_char,
  input logic                       token_valid,
  input logic [2:0]                 token_kind,
  input logic [cct_pkg::LINE_W-1:0] token_line,
  input logic                       comment_underflow
);
  import cct_pkg::*;

  // A held result stays offered until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Only a comment close both appends its character and ends a token.
  a_both: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_valid && append_valid |-> token_kind == KIND_COMMENT)
    else $error("append with non-comment token end");

  // An underflow warning comes only with the comment token it ends.
  a_under: assert property (@(posedge clk) disable iff (rst)
    out_valid && comment_underflow |->
      token_valid && append_valid && token_kind == KIND_COMMENT)
    else $error("underflow without comment end");

  // Unused fields are zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (append_valid || append_char == '0) &&
                  (token_valid || (token_kind == '0 && token_line == '0)))
    else $error("idle field not zero");

  // Reset empties the output side and releases the input.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("buffers not empty after reset");

endmodule

bind css_char_tokenizer_top cct_checker u_cct_checker (.*);
